[design/dda_ray_setup_top_defines.svh]
// Assertion macros used by the checker file of the ray setup block.
`ifndef DDA_RAY_SETUP_TOP_DEFINES_SVH
`define DDA_RAY_SETUP_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DDA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ray setup check failed");

// Next-cycle implication, masked during reset.
`define DDA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ray setup check failed");

// Next-cycle implication that also watches reset itself.
`define DDA_ASSERT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ray setup reset check failed");

`endif

[design/dda_pkg.sv]
// Shared types and constants of the ray setup block.
`default_nettype none
package dda_pkg;
    localparam int SCREEN_WIDTH_DEF = 1024;
    localparam int COL_W            = 10;
    localparam int CAM_W            = 18;
    localparam int DIR_W            = 18;
    localparam int POS_W            = 24;
    localparam int RAY_W            = 19;
    localparam int MAG_W            = 19;
    localparam int REM_W            = MAG_W + 1;
    localparam int DIST_W           = 32;
    localparam int DIV_QBITS        = 33;
    localparam int DIV_PER_STAGE    = 3;
    localparam int DIV_STAGES       = (DIV_QBITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam logic [DIST_W-1:0] SAT32 = '1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y    = 3'd5;

    typedef struct packed {
        logic signed [RAY_W-1:0] ray;
        logic                    neg;
        logic                    zero;
        logic [MAG_W-1:0]        mag;
    } axis_t;

    typedef struct packed {
        logic signed [RAY_W-1:0] ray;
        logic                    step_pos;
        logic [DIST_W-1:0]       delta;
        logic [DIST_W-1:0]       side;
    } res_t;
endpackage
`default_nettype wire

[design/dda_cam.sv]
// Column clamp and camera coordinate, two stages.
`default_nettype none
module dda_cam #(
    parameter int SCREEN_WIDTH = dda_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dda_pkg::COL_W-1:0]            column,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dda_pkg::CAM_W-1:0]     cam
);
    import dda_pkg::*;

    localparam int SW_W      = $clog2(SCREEN_WIDTH + 1);
    localparam int NUM_SHIFT = 17;
    localparam int REC_W     = NUM_SHIFT + COL_W + 1;
    localparam int PROD_W    = REC_W + COL_W;
    localparam int EST_W     = NUM_SHIFT + 1;
    localparam int CHK_W     = EST_W + SW_W;
    localparam logic [REC_W-1:0] RECIP =
        REC_W'((64'd1 << (NUM_SHIFT + COL_W)) / SCREEN_WIDTH);

    logic [1:0]              v_reg;
    logic                    rdy0, rdy1;
    logic [COL_W-1:0]        col_reg;
    logic [EST_W-1:0]        est_reg;
    logic signed [CAM_W-1:0] cam_reg;

    logic [COL_W-1:0]        col_next;
    logic [PROD_W-1:0]       prod_next;
    logic [EST_W-1:0]        est_inc, q_next;
    logic [CHK_W-1:0]        chk, num;
    logic signed [CAM_W-1:0] cam_next;

    assign rdy1      = !v_reg[1] || out_ready;
    assign rdy0      = !v_reg[0] || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = v_reg[1];
    assign cam       = cam_reg;

    always_comb begin
        // clamp out-of-range columns to the last one
        if ({{(CHK_W-COL_W){1'b0}}, column} >= CHK_W'(SCREEN_WIDTH)) begin
            col_next = COL_W'(SCREEN_WIDTH - 1);
        end else begin
            col_next = column;
        end
        prod_next = PROD_W'(col_next) * PROD_W'(RECIP);
        est_inc   = est_reg + EST_W'(1);
        chk       = CHK_W'(est_inc) * CHK_W'(SCREEN_WIDTH);
        num       = CHK_W'({col_reg, {NUM_SHIFT{1'b0}}});
        q_next    = (chk <= num) ? est_inc : est_reg;
        cam_next  = $signed(CAM_W'(q_next) - CAM_W'(65536));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy0) v_reg[0] <= in_valid;
            if (rdy1) v_reg[1] <= v_reg[0];
        end
        if (rdy0 && in_valid) begin
            col_reg <= col_next;
            est_reg <= prod_next[EST_W+COL_W-1:COL_W];
        end
        if (rdy1 && v_reg[0]) cam_reg <= cam_next;
    end
endmodule
`default_nettype wire

[design/dda_ray.sv]
// Ray direction per axis: plane times camera coordinate, then add and saturate.
`default_nettype none
module dda_ray (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [dda_pkg::CAM_W-1:0]   cam,
    input  logic signed [dda_pkg::DIR_W-1:0]   dir [2],
    input  logic signed [dda_pkg::DIR_W-1:0]   plane [2],
    output logic                               out_valid,
    input  logic                               out_ready,
    output dda_pkg::axis_t                     ax [2]
);
    import dda_pkg::*;

    localparam int PROD_W = DIR_W + CAM_W;
    localparam int SUM_W  = PROD_W - 16 + 1;

    logic [1:0]               v_reg;
    logic                     rdy0, rdy1;
    logic signed [PROD_W-1:0] prod_reg [2];
    axis_t                    ax_reg [2];
    axis_t                    ax_next [2];
    logic signed [SUM_W-1:0]  sum [2];
    logic signed [RAY_W-1:0]  ray [2];

    assign rdy1      = !v_reg[1] || out_ready;
    assign rdy0      = !v_reg[0] || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = v_reg[1];
    assign ax        = ax_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            // floor of the product by 2^16 is its upper bits, sign kept
            sum[l] = SUM_W'(dir[l]) + SUM_W'($signed(prod_reg[l][PROD_W-1:16]));
            if (sum[l] > SUM_W'(262143)) begin
                ray[l] = RAY_W'(262143);
            end else if (sum[l] < -SUM_W'(262144)) begin
                ray[l] = RAY_W'(-262144);
            end else begin
                ray[l] = sum[l][RAY_W-1:0];
            end
            ax_next[l].ray  = ray[l];
            ax_next[l].neg  = ray[l][RAY_W-1];
            ax_next[l].zero = (ray[l] == '0);
            ax_next[l].mag  = ray[l][RAY_W-1] ? MAG_W'(-ray[l]) : MAG_W'(ray[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy0) v_reg[0] <= in_valid;
            if (rdy1) v_reg[1] <= v_reg[0];
        end
        for (int l = 0; l < 2; l++) begin
            if (rdy0 && in_valid) prod_reg[l] <= plane[l] * cam;
            if (rdy1 && v_reg[0]) ax_reg[l] <= ax_next[l];
        end
    end
endmodule
`default_nettype wire

[design/dda_div.sv]
// Pipelined restoring divider for 2^32 / magnitude, a few quotient bits a stage.
`default_nettype none
module dda_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dda_pkg::axis_t                      ax_in [2],
    output logic                                out_valid,
    input  logic                                out_ready,
    output dda_pkg::axis_t                      ax_out [2],
    output logic [dda_pkg::DIV_QBITS-1:0]       quo [2]
);
    import dda_pkg::*;

    logic [DIV_STAGES-1:0]  v_reg;
    logic [DIV_STAGES:0]    rdy;
    logic [DIV_STAGES-1:0]  vin;
    axis_t                  ax_reg  [DIV_STAGES][2];
    logic [REM_W-1:0]       rem_reg [DIV_STAGES][2];
    logic [DIV_QBITS-1:0]   quo_reg [DIV_STAGES][2];
    logic [REM_W-1:0]       rem_next [DIV_STAGES][2];
    logic [DIV_QBITS-1:0]   quo_next [DIV_STAGES][2];

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign ax_out    = ax_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];

    always_comb begin
        rdy[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--) begin
            rdy[s] = !v_reg[s] || rdy[s+1];
            vin[s] = (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s - 1];
        end
    end

    always_comb begin
        logic [REM_W-1:0]     r;
        logic [DIV_QBITS-1:0] q;
        logic [MAG_W-1:0]     m;
        int                   it;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    r = '0;
                    q = '0;
                    m = ax_in[l].mag;
                end else begin
                    r = rem_reg[(s == 0) ? 0 : s - 1][l];
                    q = quo_reg[(s == 0) ? 0 : s - 1][l];
                    m = ax_reg[(s == 0) ? 0 : s - 1][l].mag;
                end
                for (int j = 0; j < DIV_PER_STAGE; j++) begin
                    it = s * DIV_PER_STAGE + j;
                    if (it < DIV_QBITS) begin
                        // dividend is a single one at its top bit
                        r = {r[REM_W-2:0], (it == 0)};
                        if (r >= REM_W'(m)) begin
                            r = r - REM_W'(m);
                            q = {q[DIV_QBITS-2:0], 1'b1};
                        end else begin
                            q = {q[DIV_QBITS-2:0], 1'b0};
                        end
                    end
                end
                rem_next[s][l] = r;
                quo_next[s][l] = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                if (rdy[s]) v_reg[s] <= vin[s];
            end
        end
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (rdy[s] && vin[s]) begin
                for (int l = 0; l < 2; l++) begin
                    ax_reg[s][l]  <= (s == 0) ? ax_in[l] : ax_reg[(s == 0) ? 0 : s - 1][l];
                    rem_reg[s][l] <= rem_next[s][l];
                    quo_reg[s][l] <= quo_next[s][l];
                end
            end
        end
    end
endmodule
`default_nettype wire

[design/dda_side.sv]
// Delta saturation and initial side distance, two stages.
`default_nettype none
module dda_side (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  dda_pkg::axis_t                     ax [2],
    input  logic [dda_pkg::DIV_QBITS-1:0]      quo [2],
    input  logic [15:0]                        frac [2],
    output logic                               out_valid,
    input  logic                               out_ready,
    output dda_pkg::res_t                      res [2]
);
    import dda_pkg::*;

    localparam int DW     = 17;
    localparam int PROD_W = DW + DIST_W;

    logic [1:0]          v_reg;
    logic                rdy0, rdy1;
    axis_t               ax_reg [2];
    logic [DIST_W-1:0]   delta_reg [2];
    logic [PROD_W-1:0]   prod_reg [2];
    res_t                res_reg [2];

    logic [DIST_W-1:0]   delta_next [2];
    logic [DW-1:0]       gap [2];
    logic [PROD_W-1:0]   prod_next [2];
    logic [PROD_W-17:0]  scaled [2];
    res_t                res_next [2];

    assign rdy1      = !v_reg[1] || out_ready;
    assign rdy0      = !v_reg[0] || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = v_reg[1];
    assign res       = res_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            delta_next[l] = (quo[l][DIV_QBITS-1] || ax[l].zero) ? SAT32 :
                            quo[l][DIST_W-1:0];
            gap[l] = ax[l].neg ? {1'b0, frac[l]} : DW'(65536) - {1'b0, frac[l]};
            prod_next[l] = PROD_W'(gap[l]) * PROD_W'(delta_next[l]);

            scaled[l] = prod_reg[l][PROD_W-1:16];
            res_next[l].ray      = ax_reg[l].ray;
            res_next[l].step_pos = !ax_reg[l].neg;
            res_next[l].delta    = delta_reg[l];
            res_next[l].side     = (ax_reg[l].zero || scaled[l][DIST_W]) ? SAT32 :
                                   scaled[l][DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy0) v_reg[0] <= in_valid;
            if (rdy1) v_reg[1] <= v_reg[0];
        end
        for (int l = 0; l < 2; l++) begin
            if (rdy0 && in_valid) begin
                ax_reg[l]    <= ax[l];
                delta_reg[l] <= delta_next[l];
                prod_reg[l]  <= prod_next[l];
            end
            if (rdy1 && v_reg[0]) res_reg[l] <= res_next[l];
        end
    end
endmodule
`default_nettype wire

[design/dda_ray_setup_top.sv]
// Top level of the DDA ray setup block: registers, pipeline and result ports.
// One screen column request goes in, one ray setup comes out: ray direction
// (view_dir + plane * cam, cam = 2*column/SCREEN_WIDTH - 1), |1/ray| deltas,
// step signs, the floor of the player position as start cell and the initial
// side distances. A new column is taken every cycle while the output side
// does not stall. The pipeline has two stages for the camera coordinate (a
// reciprocal multiply with one correction), two for the ray direction
// multiply-add, 11 for the reciprocal divider at three quotient bits a
// stage, and two for the side distance multiply and saturation. Every stage
// has its own valid bit and holds when the stage after it is full, so a
// stalled output fills bubbles upstream before it backs up into s_ready.
// Configuration writes are always taken (cfg_ready is high) and act at once;
// write them only while no column request is in flight.
`default_nettype none
module dda_ray_setup_top #(
    parameter int SCREEN_WIDTH = dda_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // column requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dda_pkg::COL_W-1:0]            s_column,
    // ray setup results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dda_pkg::RAY_W-1:0]     m_ray_dir_x,
    output logic signed [dda_pkg::RAY_W-1:0]     m_ray_dir_y,
    output logic [dda_pkg::DIST_W-1:0]           m_delta_x,
    output logic [dda_pkg::DIST_W-1:0]           m_delta_y,
    output logic                                 m_step_x_pos,
    output logic                                 m_step_y_pos,
    output logic [7:0]                           m_cell_x,
    output logic [7:0]                           m_cell_y,
    output logic [dda_pkg::DIST_W-1:0]           m_side_x,
    output logic [dda_pkg::DIST_W-1:0]           m_side_y,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dda_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dda_pkg::POS_W-1:0]            cfg_data
);
    import dda_pkg::*;

    logic [POS_W-1:0]        player_x_reg, player_y_reg;
    logic signed [DIR_W-1:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [DIR_W-1:0] plane_x_reg, plane_y_reg;

    logic                    cam_valid, cam_ready;
    logic signed [CAM_W-1:0] cam;
    logic                    ray_valid, ray_ready;
    axis_t                   ray_ax [2];
    logic                    div_valid, div_ready;
    axis_t                   div_ax [2];
    logic [DIV_QBITS-1:0]    div_quo [2];
    res_t                    res [2];
    logic signed [DIR_W-1:0] dir [2];
    logic signed [DIR_W-1:0] plane [2];
    logic [15:0]             frac [2];

    assign cfg_ready = 1'b1;

    // Take register writes; ignore indexes beyond the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_x_reg   <= '0;
            player_y_reg   <= '0;
            view_dir_x_reg <= DIR_W'(65536);
            view_dir_y_reg <= '0;
            plane_x_reg    <= '0;
            plane_y_reg    <= DIR_W'(43254);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PLAYER_X:   player_x_reg   <= cfg_data;
                REG_PLAYER_Y:   player_y_reg   <= cfg_data;
                REG_VIEW_DIR_X: view_dir_x_reg <= cfg_data[DIR_W-1:0];
                REG_VIEW_DIR_Y: view_dir_y_reg <= cfg_data[DIR_W-1:0];
                REG_PLANE_X:    plane_x_reg    <= cfg_data[DIR_W-1:0];
                REG_PLANE_Y:    plane_y_reg    <= cfg_data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    // Lane 0 is x, lane 1 is y throughout the pipeline.
    assign dir[0]   = view_dir_x_reg;
    assign dir[1]   = view_dir_y_reg;
    assign plane[0] = plane_x_reg;
    assign plane[1] = plane_y_reg;
    assign frac[0]  = player_x_reg[15:0];
    assign frac[1]  = player_y_reg[15:0];

    dda_cam #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_cam (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .column    (s_column),
        .out_valid (cam_valid),
        .out_ready (cam_ready),
        .cam       (cam)
    );

    dda_ray u_ray (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cam_valid),
        .in_ready  (cam_ready),
        .cam       (cam),
        .dir       (dir),
        .plane     (plane),
        .out_valid (ray_valid),
        .out_ready (ray_ready),
        .ax        (ray_ax)
    );

    dda_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ray_valid),
        .in_ready  (ray_ready),
        .ax_in     (ray_ax),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .ax_out    (div_ax),
        .quo       (div_quo)
    );

    dda_side u_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .ax        (div_ax),
        .quo       (div_quo),
        .frac      (frac),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .res       (res)
    );

    // Drive result fields; the start cell comes straight from the position.
    assign m_ray_dir_x  = res[0].ray;
    assign m_ray_dir_y  = res[1].ray;
    assign m_delta_x    = res[0].delta;
    assign m_delta_y    = res[1].delta;
    assign m_step_x_pos = res[0].step_pos;
    assign m_step_y_pos = res[1].step_pos;
    assign m_side_x     = res[0].side;
    assign m_side_y     = res[1].side;
    assign m_cell_x     = player_x_reg[POS_W-1:16];
    assign m_cell_y     = player_y_reg[POS_W-1:16];
endmodule
`default_nettype wire

[design/dda_chk.sv]
// Port-level checker for the ray setup block and its bind.
`default_nettype none
`include "dda_ray_setup_top_defines.svh"
module dda_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [18:0] m_ray_dir_x,
    input wire logic [31:0] m_delta_x,
    input wire logic [31:0] m_side_x,
    input wire logic        m_step_x_pos,
    input wire logic        cfg_ready
);
    `DDA_ASSERT_RST(a_empty_after_reset, aclk, !aresetn, !m_valid)
    `DDA_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_delta_x) && $stable(m_side_x))
    `DDA_ASSERT_NOW(a_zero_dir_sat, aclk, aresetn, m_valid && m_ray_dir_x == 19'd0, m_step_x_pos && m_delta_x == 32'hFFFFFFFF && m_side_x == 32'hFFFFFFFF)
    `DDA_ASSERT_NOW(a_step_sign, aclk, aresetn, m_valid, m_step_x_pos == !m_ray_dir_x[18] && cfg_ready)
endmodule

bind dda_ray_setup_top dda_chk u_dda_chk (.*);
`default_nettype wire
